// File: hdl/i2cbb_pkg.sv
// Shared types and constants for the two-wire bit-level master.
package i2cbb_pkg;

   // Command kinds carried with each input item.
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   // Register indexes on the configuration port.
   localparam logic REG_ACK_POLL_LIMIT  = 1'b0;
   localparam logic REG_TICKS_PER_PHASE = 1'b1;

   // Register reset values.
   localparam logic [15:0] ACK_POLL_LIMIT_RESET  = 16'd1000;
   localparam logic [7:0]  TICKS_PER_PHASE_RESET = 8'd1;

   // Bits in one byte on the bus.
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Bus widths.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Configuration seen by the sequencer.
   typedef struct packed {
      logic [15:0] ack_poll_limit;
      logic [7:0]  ticks_per_phase;
   } cfg_type;

   // One input item.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       sda_in;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } rsp_item_type;

endpackage

// File: hdl/i2cbb_csr.sv
// Configuration register bank with an APB-style access port.
module i2cbb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [i2cbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2cbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2cbb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output i2cbb_pkg::cfg_type               cfg
);
   import i2cbb_pkg::*;

   logic [15:0] ack_poll_limit_ff;
   logic [7:0]  ticks_per_phase_ff;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_poll_limit_ff  <= ACK_POLL_LIMIT_RESET;
         ticks_per_phase_ff <= TICKS_PER_PHASE_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_ACK_POLL_LIMIT:  ack_poll_limit_ff  <= csr_pwdata[15:0];
            REG_TICKS_PER_PHASE: ticks_per_phase_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read data.
   always_comb begin
      case (reg_sel)
         REG_ACK_POLL_LIMIT:  csr_prdata = {16'd0, ack_poll_limit_ff};
         REG_TICKS_PER_PHASE: csr_prdata = {24'd0, ticks_per_phase_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.ack_poll_limit  = ack_poll_limit_ff;
   assign cfg.ticks_per_phase = ticks_per_phase_ff;

endmodule

// File: hdl/i2cbb_seq.sv
// Line sequencer: phase state and the per-tick next-state and result logic.
module i2cbb_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  i2cbb_pkg::req_item_type item,
   input  i2cbb_pkg::cfg_type      cfg,
   output i2cbb_pkg::rsp_item_type result
);
   import i2cbb_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_A    = 4'd1,
      PH_ST_B    = 4'd2,
      PH_SP_A    = 4'd3,
      PH_SP_B    = 4'd4,
      PH_SP_C    = 4'd5,
      PH_W_LOW   = 4'd6,
      PH_W_HIGH  = 4'd7,
      PH_GA_LOW  = 4'd8,
      PH_GA_HIGH = 4'd9,
      PH_GA_POLL = 4'd10,
      PH_R_PRE   = 4'd11,
      PH_R_HIGH  = 4'd12,
      PH_R_LOW   = 4'd13,
      PH_K_LOW   = 4'd14,
      PH_K_HIGH  = 4'd15
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] poll_count_ff, poll_count_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic        scl_level_ff, scl_level_in;
   logic        sda_level_ff, sda_level_in;
   logic        nack_choice_ff, nack_choice_in;

   logic [7:0]  hold_lim;
   logic [15:0] poll_lim;
   logic [7:0]  tick_inc;
   logic [15:0] poll_inc;
   logic [3:0]  bit_inc;
   logic        hold_done;
   logic        done;
   logic        miss;
   logic [7:0]  rx;

   // A zero register value behaves as one.
   assign hold_lim  = (cfg.ticks_per_phase == 8'd0) ? 8'd1 : cfg.ticks_per_phase;
   assign poll_lim  = (cfg.ack_poll_limit == 16'd0) ? 16'd1 : cfg.ack_poll_limit;
   assign tick_inc  = tick_count_ff + 8'd1;
   assign poll_inc  = poll_count_ff + 16'd1;
   assign bit_inc   = bit_count_ff + 4'd1;
   assign hold_done = (tick_inc >= hold_lim);

   // Next state and result for this tick.
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_byte_in  = shift_byte_ff;
      poll_count_in  = poll_count_ff;
      tick_count_in  = tick_count_ff;
      scl_level_in   = scl_level_ff;
      sda_level_in   = sda_level_ff;
      nack_choice_in = nack_choice_ff;
      done           = 1'b0;
      miss           = 1'b0;
      rx             = 8'd0;

      case (phase_ff)
         // Idle: take a new command; unknown kinds are dropped.
         PH_IDLE: begin
            case (item.kind)
               KIND_START: begin
                  phase_in      = PH_ST_A;
                  scl_level_in  = 1'b1;
                  sda_level_in  = 1'b1;
                  tick_count_in = 8'd0;
               end
               KIND_STOP: begin
                  phase_in      = PH_SP_A;
                  scl_level_in  = 1'b0;
                  sda_level_in  = 1'b0;
                  tick_count_in = 8'd0;
               end
               KIND_WRITE: begin
                  shift_byte_in = item.tx_byte;
                  bit_count_in  = 4'd0;
                  phase_in      = PH_W_LOW;
                  scl_level_in  = 1'b0;
                  sda_level_in  = item.tx_byte[7];
                  tick_count_in = 8'd0;
               end
               KIND_READ: begin
                  shift_byte_in  = 8'd0;
                  bit_count_in   = 4'd0;
                  nack_choice_in = item.send_nack;
                  phase_in       = PH_R_PRE;
                  scl_level_in   = 1'b0;
                  sda_level_in   = 1'b1;
                  tick_count_in  = 8'd0;
               end
               default: ;
            endcase
         end

         // Acknowledge poll: one sample per tick until low or the limit.
         PH_GA_POLL: begin
            if (!item.sda_in) begin
               scl_level_in  = 1'b0;
               phase_in      = PH_IDLE;
               tick_count_in = 8'd0;
               done          = 1'b1;
            end else begin
               poll_count_in = poll_inc;
               if (poll_inc >= poll_lim) begin
                  scl_level_in  = 1'b0;
                  phase_in      = PH_IDLE;
                  tick_count_in = 8'd0;
                  done          = 1'b1;
                  miss          = 1'b1;
               end
            end
         end

         // Timed phases: advance once the phase has been held long enough.
         default: begin
            tick_count_in = tick_inc;
            if (hold_done) begin
               tick_count_in = 8'd0;
               case (phase_ff)
                  PH_ST_A: begin
                     phase_in     = PH_ST_B;
                     scl_level_in = 1'b1;
                     sda_level_in = 1'b0;
                  end
                  PH_ST_B: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_SP_A: begin
                     phase_in     = PH_SP_B;
                     scl_level_in = 1'b1;
                     sda_level_in = 1'b0;
                  end
                  PH_SP_B: begin
                     phase_in     = PH_SP_C;
                     scl_level_in = 1'b1;
                     sda_level_in = 1'b1;
                  end
                  PH_SP_C: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_W_LOW: begin
                     phase_in     = PH_W_HIGH;
                     scl_level_in = 1'b1;
                  end
                  PH_W_HIGH: begin
                     shift_byte_in = {shift_byte_ff[6:0], 1'b0};
                     bit_count_in  = bit_inc;
                     scl_level_in  = 1'b0;
                     if (bit_inc >= BITS_PER_BYTE) begin
                        phase_in     = PH_GA_LOW;
                        sda_level_in = 1'b1;
                     end else begin
                        phase_in     = PH_W_LOW;
                        sda_level_in = shift_byte_ff[6];
                     end
                  end
                  PH_GA_LOW: begin
                     phase_in     = PH_GA_HIGH;
                     scl_level_in = 1'b1;
                     sda_level_in = 1'b1;
                  end
                  PH_GA_HIGH: begin
                     phase_in      = PH_GA_POLL;
                     poll_count_in = 16'd0;
                  end
                  PH_R_PRE: begin
                     phase_in     = PH_R_HIGH;
                     scl_level_in = 1'b1;
                     sda_level_in = 1'b1;
                  end
                  PH_R_HIGH: begin
                     shift_byte_in = {shift_byte_ff[6:0], item.sda_in};
                     phase_in      = PH_R_LOW;
                     scl_level_in  = 1'b0;
                     sda_level_in  = 1'b1;
                  end
                  PH_R_LOW: begin
                     bit_count_in = bit_inc;
                     if (bit_inc >= BITS_PER_BYTE) begin
                        phase_in     = PH_K_LOW;
                        scl_level_in = 1'b0;
                        sda_level_in = nack_choice_ff;
                     end else begin
                        phase_in     = PH_R_HIGH;
                        scl_level_in = 1'b1;
                        sda_level_in = 1'b1;
                     end
                  end
                  PH_K_LOW: begin
                     phase_in     = PH_K_HIGH;
                     scl_level_in = 1'b1;
                     sda_level_in = nack_choice_ff;
                  end
                  PH_K_HIGH: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                     rx       = shift_byte_ff;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      endcase
   end

   // State update, one tick per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 4'd0;
         shift_byte_ff  <= 8'd0;
         poll_count_ff  <= 16'd0;
         tick_count_ff  <= 8'd0;
         scl_level_ff   <= 1'b1;
         sda_level_ff   <= 1'b1;
         nack_choice_ff <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_byte_ff  <= shift_byte_in;
         poll_count_ff  <= poll_count_in;
         tick_count_ff  <= tick_count_in;
         scl_level_ff   <= scl_level_in;
         sda_level_ff   <= sda_level_in;
         nack_choice_ff <= nack_choice_in;
      end
   end

   assign result.scl_out     = scl_level_in;
   assign result.sda_out     = sda_level_in;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.rx_byte     = rx;
   assign result.ack_missing = miss;

endmodule

// File: hdl/i2c_bitbang_master_top.sv
// Top level of the two-wire bit-level master: input register, sequencer,
// result register and configuration port.
//
// Each input item is one timing tick of the bus sequencer and gives exactly
// one result item with the clock and data drive levels, busy, done, the
// received byte on the done tick of a read and the missing-acknowledge flag
// on the done tick of a write. The block takes one item per clock cycle
// while the result side is not stalled. An item passes through an input
// register and a result register. A stalled result keeps the next item
// waiting in the input register, and while that register is full the input
// is held off as well; an empty input register still takes one item. The
// sequencer state advances once per item, through the combinational
// next-state logic between those registers. The user must write configuration
// only while no item is in flight; the block itself does not enforce this.
module i2c_bitbang_master_top (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel. tdata: [7:0] tx_byte, [8] send_nack, [9] sda_in, rest zero.
   // tuser: [2:0] kind.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,
   input  logic [2:0]                       req_tuser,
   // Result channel. tdata: [0] scl_out, [1] sda_out, [2] busy_res,
   // [3] done_res, [11:4] rx_byte, [12] ack_missing, [15:13] zero.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [i2cbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2cbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2cbb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import i2cbb_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   rsp_item_type seq_result;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   logic         advance;

   i2cbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The held item moves on when the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.kind      <= req_tuser;
         in_item_ff.tx_byte   <= req_tdata[7:0];
         in_item_ff.send_nack <= req_tdata[8];
         in_item_ff.sda_in    <= req_tdata[9];
      end
   end

   i2cbb_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (seq_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_item_ff.ack_missing, rsp_item_ff.rx_byte,
                        rsp_item_ff.done_res, rsp_item_ff.busy_res,
                        rsp_item_ff.sda_out, rsp_item_ff.scl_out};

   // A finished command always leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.done_res |-> !rsp_item_ff.busy_res)
      else $error("done reported while still busy");

   // The timeout flag and received byte appear only on a done tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.ack_missing || (rsp_item_ff.rx_byte != 8'd0))
      |-> rsp_item_ff.done_res)
      else $error("result flag outside a done tick");

   // A stalled result register must not be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("stalled result lost");

   // An item is never taken from the input register while the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_valid_ff || rsp_tready))
      else $error("item advanced into a full result register");

endmodule

// File: tb/i2cbb_bus_checker.sv
// Checker for the two-wire master: predicts every result item and compares it with the block.
`timescale 1ns / 100ps

module i2cbb_bus_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // [7:0] tx_byte, [8] send_nack,
                                                         // [9] sda_in
   input  logic [2:0]                       req_tuser,   // [2:0] kind
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,   // [0] scl_out, [1] sda_out,
                                                         // [2] busy_res, [3] done_res,
                                                         // [11:4] rx_byte, [12] ack_missing
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [i2cbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2cbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                             csr_pready,
   output int                               mismatches,
   output int                               outstanding,
   output int                               compared
);
   import i2cbb_pkg::*;

   // Phases of the line sequencer.
   typedef enum logic [3:0] {
      BUS_IDLE, START_A, START_B, STOP_A, STOP_B, STOP_C,
      WR_LOW, WR_HIGH, ACK_LOW, ACK_HIGH, ACK_POLL,
      RD_PRE, RD_HIGH, RD_LOW, RESP_LOW, RESP_HIGH
   } bus_phase_type;

   // Predicted sequencer state and register copies.
   bus_phase_type phase;
   logic [3:0]    bits_done;
   logic [7:0]    shreg;
   logic [15:0]   polls;
   logic [7:0]    hold;
   logic          scl_lvl;
   logic          sda_lvl;
   logic          nack_lvl;
   logic [15:0]   poll_limit;
   logic [7:0]    phase_ticks;

   rsp_item_type bus_levels_q[$];
   int           errs;
   int           checks;

   // Moves to a new phase with the given line levels.
   function automatic void go(bus_phase_type next, logic scl, logic sda);
      phase   = next;
      scl_lvl = scl;
      sda_lvl = sda;
      hold    = '0;
   endfunction

   // Ends the current command.
   function automatic void park();
      phase = BUS_IDLE;
      hold  = '0;
   endfunction

   // Counts one tick of the current phase; true once the phase has been held long enough.
   function automatic bit hold_elapsed();
      logic [7:0] lim;
      lim  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
      hold = hold + 8'd1;
      return hold >= lim;
   endfunction

   // Advances the sequencer by one tick and returns the bus levels it shows.
   function automatic rsp_item_type next_bus_levels(logic [2:0] kind, logic [7:0] tx,
                                                    logic nack, logic sda);
      rsp_item_type r;
      logic [15:0]  lim;
      r = '0;
      if (phase == BUS_IDLE) begin
         case (kind)
            KIND_START: go(START_A, 1'b1, 1'b1);
            KIND_STOP:  go(STOP_A, 1'b0, 1'b0);
            KIND_WRITE: begin
               shreg     = tx;
               bits_done = '0;
               go(WR_LOW, 1'b0, tx[7]);
            end
            KIND_READ: begin
               shreg     = '0;
               bits_done = '0;
               nack_lvl  = nack;
               go(RD_PRE, 1'b0, 1'b1);
            end
            default: ;
         endcase
      end else if (phase == ACK_POLL) begin
         // One sample per tick; a low line is the acknowledge.
         lim = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
         if (!sda) begin
            scl_lvl = 1'b0;
            park();
            r.done_res = 1'b1;
         end else begin
            polls = polls + 16'd1;
            if (polls >= lim) begin
               scl_lvl = 1'b0;
               park();
               r.done_res    = 1'b1;
               r.ack_missing = 1'b1;
            end
         end
      end else if (hold_elapsed()) begin
         case (phase)
            START_A: go(START_B, 1'b1, 1'b0);
            START_B: begin
               park();
               r.done_res = 1'b1;
            end
            STOP_A: go(STOP_B, 1'b1, 1'b0);
            STOP_B: go(STOP_C, 1'b1, 1'b1);
            STOP_C: begin
               park();
               r.done_res = 1'b1;
            end
            WR_LOW: go(WR_HIGH, 1'b1, sda_lvl);
            WR_HIGH: begin
               shreg     = {shreg[6:0], 1'b0};
               bits_done = bits_done + 4'd1;
               if (bits_done >= BITS_PER_BYTE) go(ACK_LOW, 1'b0, 1'b1);
               else go(WR_LOW, 1'b0, shreg[7]);
            end
            ACK_LOW: go(ACK_HIGH, 1'b1, 1'b1);
            ACK_HIGH: begin
               phase = ACK_POLL;
               hold  = '0;
               polls = '0;
            end
            RD_PRE: go(RD_HIGH, 1'b1, 1'b1);
            RD_HIGH: begin
               shreg = {shreg[6:0], sda};
               go(RD_LOW, 1'b0, 1'b1);
            end
            RD_LOW: begin
               bits_done = bits_done + 4'd1;
               if (bits_done >= BITS_PER_BYTE) go(RESP_LOW, 1'b0, nack_lvl);
               else go(RD_HIGH, 1'b1, 1'b1);
            end
            RESP_LOW: go(RESP_HIGH, 1'b1, nack_lvl);
            RESP_HIGH: begin
               park();
               r.done_res = 1'b1;
               r.rx_byte  = shreg;
            end
            default: park();
         endcase
      end
      r.scl_out  = scl_lvl;
      r.sda_out  = sda_lvl;
      r.busy_res = (phase != BUS_IDLE);
      return r;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errs++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         phase       = BUS_IDLE;
         bits_done   = '0;
         shreg       = '0;
         polls       = '0;
         hold        = '0;
         scl_lvl     = 1'b1;
         sda_lvl     = 1'b1;
         nack_lvl    = 1'b0;
         poll_limit  = ACK_POLL_LIMIT_RESET;
         phase_ticks = TICKS_PER_PHASE_RESET;
         bus_levels_q.delete();
      end else begin
         // Register writes complete on the access cycle.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_TICKS_PER_PHASE) phase_ticks = csr_pwdata[7:0];
            else poll_limit = csr_pwdata[15:0];
         end

         // Every accepted item is one tick and yields one result item.
         if (req_tvalid && req_tready)
            bus_levels_q.push_back(next_bus_levels(req_tuser, req_tdata[7:0],
                                                   req_tdata[8], req_tdata[9]));

         // Compare each returned item with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got             = '0;
            got.scl_out     = rsp_tdata[0];
            got.sda_out     = rsp_tdata[1];
            got.busy_res    = rsp_tdata[2];
            got.done_res    = rsp_tdata[3];
            got.rx_byte     = rsp_tdata[11:4];
            got.ack_missing = rsp_tdata[12];
            if (bus_levels_q.size() == 0) begin
               $error("Result item arrived with no prediction waiting: %0h", rsp_tdata);
               errs++;
            end else begin
               want = bus_levels_q.pop_front();
               compare_field("scl_out", int'(want.scl_out), int'(got.scl_out));
               compare_field("sda_out", int'(want.sda_out), int'(got.sda_out));
               compare_field("busy_res", int'(want.busy_res), int'(got.busy_res));
               compare_field("done_res", int'(want.done_res), int'(got.done_res));
               compare_field("rx_byte", int'(want.rx_byte), int'(got.rx_byte));
               compare_field("ack_missing", int'(want.ack_missing),
                             int'(got.ack_missing));
               checks++;
            end
         end
      end
      mismatches  <= errs;
      outstanding <= bus_levels_q.size();
      compared    <= checks;
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the two-wire master: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb_top;
   import i2cbb_pkg::*;

   // Kinds outside the command set, ignored by the block.
   localparam logic [2:0] KIND_UNKNOWN_LO  = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN_MID = 3'd6;
   localparam logic [2:0] KIND_UNKNOWN_HI  = 3'd7;

   // How the data line is driven during a command.
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;
   localparam int SDA_ACK_AT = 3;

   // Result bits watched by the stimulus.
   localparam int RSP_DONE_BIT = 3;
   localparam int RSP_MISS_BIT = 12;

   localparam int CYCLE_LIMIT     = 4_000_000;
   localparam int RANDOM_PER_STEP = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;   // [7:0] tx_byte, [8] send_nack, [9] sda_in
   logic [2:0]            req_tuser = '0;   // [2:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [15:0]           rsp_tdata;        // [0] scl_out, [1] sda_out, [2] busy_res,
                                            // [3] done_res, [11:4] rx_byte, [12] ack_missing
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int  mismatches;
   int  outstanding;
   int  compared;
   int  done_total = 0;
   int  missing_total = 0;
   int  cycle_count = 0;
   int  rsp_hold = 0;
   bit  gaps_on = 1'b1;
   int  items_sent = 0;
   int  noise_items = 0;
   int  settings = 0;
   int  starts = 0;
   int  stops = 0;
   int  writes = 0;
   int  reads = 0;
   int  cur_limit = int'(ACK_POLL_LIMIT_RESET);
   int  cur_tpp = int'(TICKS_PER_PHASE_RESET);

   i2c_bitbang_master_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   i2cbb_bus_checker bus_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .compared    (compared)
   );

   always #5 clock = ~clock;

   // Result side stalls now and then for a random burst.
   always_ff @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Completed commands seen on the result side pace the stimulus.
   always_ff @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && rsp_tdata[RSP_DONE_BIT]) begin
         done_total <= done_total + 1;
         if (rsp_tdata[RSP_MISS_BIT]) missing_total <= missing_total + 1;
      end
   end

   // Watchdog.
   always_ff @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d items outstanding", cycle_count,
                  outstanding);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Offers one item, after an occasional idle burst, and waits for it to be taken.
   task automatic send_item(input logic [2:0] kind, input logic [7:0] tx, input logic nack,
                            input logic sda);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, sda, nack, tx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Waits until every prediction has been answered and the block has settled.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // One write on the configuration port; back-to-back writes skip the idle state.
   task automatic write_reg(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_regs(input int limit, input int tpp);
      quiesce();
      write_reg(REG_ACK_POLL_LIMIT, limit);
      write_reg(REG_TICKS_PER_PHASE, tpp);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_limit = limit;
      cur_tpp   = tpp;
      settings++;
   endtask

   function automatic logic line_level(int mode, int k, int ack_at);
      case (mode)
         SDA_LOW:    return 1'b0;
         SDA_HIGH:   return 1'b1;
         SDA_ACK_AT: return (k < ack_at) ? 1'b1 : 1'b0;
         default:    return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Issues a command while idle and ticks until its completion is seen.
   // With stray set, the first tick carries a command of its own, which arrives while busy.
   task automatic run_command(input logic [2:0] kind, input logic [7:0] tx, input logic nack,
                              input int mode, input int ack_at, input bit stray);
      int         base;
      int         k;
      logic [2:0] tick_kind;
      base = done_total;
      case (kind)
         KIND_START: starts++;
         KIND_STOP:  stops++;
         KIND_WRITE: writes++;
         KIND_READ:  reads++;
         default: ;
      endcase
      send_item(kind, tx, nack, line_level(mode, 0, ack_at));
      k = 1;
      while (done_total == base) begin
         if (k == 1 && stray) tick_kind = 3'($urandom_range(KIND_START, KIND_UNKNOWN_HI));
         else if ($urandom_range(0, 15) == 0)
            tick_kind = 3'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
         else tick_kind = KIND_TICK;
         send_item(tick_kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   line_level(mode, k, ack_at));
         k++;
      end
   endtask

   // One byte in either direction with a random acknowledge point or line pattern.
   task automatic random_transfer();
      int eff_tpp;
      int eff_lim;
      eff_tpp = (cur_tpp == 0) ? 1 : cur_tpp;
      eff_lim = (cur_limit == 0) ? 1 : cur_limit;
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 5))
            0: run_command(KIND_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_LOW, 0, 1'b0);
            1: run_command(KIND_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_HIGH, 0,
                           1'($urandom_range(0, 1)));
            default: run_command(KIND_WRITE, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), SDA_ACK_AT,
                                 18 * eff_tpp + 1 + int'($urandom_range(0, eff_lim)),
                                 $urandom_range(0, 3) == 0);
         endcase
      end else begin
         run_command(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 7) == 0) ? int'($urandom_range(SDA_LOW, SDA_HIGH)) :
                     SDA_RANDOM, 0, $urandom_range(0, 3) == 0);
      end
   endtask

   // Mostly complete transactions, now and then idle noise or a fragment.
   task automatic random_transaction();
      int n;
      case ($urandom_range(0, 9))
         0: begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               send_item(($urandom_range(0, 1)) ?
                         KIND_TICK : 3'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
               noise_items++;
            end
         end
         1: begin
            case ($urandom_range(0, 2))
               0: run_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
               1: run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1);
               default: random_transfer();
            endcase
         end
         default: begin
            run_command(KIND_START, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 0,
                        $urandom_range(0, 3) == 0);
            n = $urandom_range(1, 3);
            repeat (n) random_transfer();
            run_command(KIND_STOP, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 0,
                        $urandom_range(0, 3) == 0);
         end
      endcase
   endtask

   initial begin
      int target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: idle ticks, unknown kinds, every command.
      send_item(KIND_TICK, 8'hFF, 1'b1, 1'b1);
      send_item(KIND_UNKNOWN_LO, 8'h00, 1'b0, 1'b0);
      send_item(KIND_UNKNOWN_MID, 8'h5A, 1'b1, 1'b0);
      send_item(KIND_UNKNOWN_HI, 8'hA5, 1'b0, 1'b1);
      run_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1);
      run_command(KIND_WRITE, 8'h00, 1'b0, SDA_LOW, 0, 1'b0);
      run_command(KIND_WRITE, 8'hFF, 1'b1, SDA_ACK_AT, 25, 1'b1);
      run_command(KIND_READ, 8'h00, 1'b0, SDA_LOW, 0, 1'b0);
      run_command(KIND_READ, 8'hFF, 1'b1, SDA_HIGH, 0, 1'b1);
      run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);

      // Zero in both registers behaves as one.
      set_regs(0, 0);
      run_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
      run_command(KIND_WRITE, 8'h81, 1'b0, SDA_HIGH, 0, 1'b0);
      run_command(KIND_WRITE, 8'h7E, 1'b0, SDA_ACK_AT, 19, 1'b0);
      run_command(KIND_READ, 8'h00, 1'b1, SDA_RANDOM, 0, 1'b0);
      run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1);

      // Full-width acknowledge limit with a late acknowledge, then a longer phase hold.
      set_regs(16'hFFFF, 1);
      run_command(KIND_WRITE, 8'hC3, 1'b0, SDA_ACK_AT, 18 + 40, 1'b0);
      set_regs(16'hFFFF, 5);
      run_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);
      run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0);

      // Random part over several settings; the last one runs without idling.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_regs($urandom_range(1, 12), 1);
            1: set_regs($urandom_range(1, 40), $urandom_range(1, 3));
            2: set_regs(1, 2);
            default: begin
               gaps_on <= 1'b0;
               set_regs($urandom_range(1, 20), 1);
            end
         endcase
         target = items_sent - noise_items + RANDOM_PER_STEP;
         while (items_sent - noise_items < target) random_transaction();
      end

      quiesce();
      repeat (8) @(posedge clock);
      $display("Bus commands issued: %0d starts, %0d stops, %0d writes", starts, stops,
               writes);
      $display("(%0d unacknowledged), %0d reads", missing_total, reads);
      $display("%0d ticks driven under %0d register settings, %0d result items compared",
               items_sent, settings, compared);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
